// ===== sv/ipv_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv_pkg
// Constants and types for the IP address text validator.
// ----------------------------------------------------------------------------
package ipv_pkg;

    typedef enum logic [1:0] {
        VERDICT_IPV4  = 2'd0,
        VERDICT_IPV6  = 2'd1,
        VERDICT_ERROR = 2'd2
    } verdict_t;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
    localparam logic [1:0] V4_MAX_DOTS   = 2'd3;
    localparam logic [1:0] V4_MAX_LEN    = 2'd3;
    localparam logic [2:0] V6_MAX_COLONS = 3'd7;
    localparam logic [2:0] V6_MAX_LEN    = 3'd4;

endpackage

// ===== sv/ip_address_text_validator_top.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_validator_top
// Classifies a character stream as an IPv4 address, an IPv6 address or error.
// ----------------------------------------------------------------------------
// The verdict appears on m_valid in the cycle after the last character
// is accepted. Throughput: one character per cycle; the per-character
// update is a single pass of compares and a times-ten add into the state
// registers. The input stalls only while a verdict waits with m_ready low.
// Reset (aresetn low, synchronous) clears all checker state and empties the
// result register.
module ip_address_text_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict
);

    logic       seen_dot_reg, seen_dot_next;
    logic       seen_colon_reg, seen_colon_next;
    logic       v4_fail_reg, v4_fail_next;
    logic [1:0] v4_dot_count_reg, v4_dot_count_next;
    logic [1:0] v4_group_len_reg, v4_group_len_next;
    logic [7:0] v4_group_value_reg, v4_group_value_next;
    logic       v4_leading_zero_reg, v4_leading_zero_next;
    logic       v6_fail_reg, v6_fail_next;
    logic [2:0] v6_colon_count_reg, v6_colon_count_next;
    logic [2:0] v6_group_len_reg, v6_group_len_next;
    logic       v6_saw_upper_reg, v6_saw_upper_next;
    logic       v6_saw_lower_reg, v6_saw_lower_next;

    logic                m_valid_reg;
    ipv_pkg::verdict_t   m_verdict_reg, verdict_next;

    logic       accept;
    logic       is_dot, is_colon, is_dig, is_low, is_up;
    logic [3:0] digit;
    logic [9:0] v4_value_wide;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    always_comb begin
        is_dot   = (s_in_char == ipv_pkg::CHAR_DOT);
        is_colon = (s_in_char == ipv_pkg::CHAR_COLON);
        is_dig   = (s_in_char >= ipv_pkg::CHAR_0)  && (s_in_char <= ipv_pkg::CHAR_9);
        is_low   = (s_in_char >= ipv_pkg::CHAR_LA) && (s_in_char <= ipv_pkg::CHAR_LF);
        is_up    = (s_in_char >= ipv_pkg::CHAR_UA) && (s_in_char <= ipv_pkg::CHAR_UF);
        digit    = 4'(s_in_char - ipv_pkg::CHAR_0);
        v4_value_wide = ({2'b00, v4_group_value_reg} * 10'd10) + {6'd0, digit};

        seen_dot_next   = seen_dot_reg || is_dot;
        seen_colon_next = seen_colon_reg || is_colon;

        // IPv4 checker: a failed checker holds its counters
        v4_fail_next         = v4_fail_reg;
        v4_dot_count_next    = v4_dot_count_reg;
        v4_group_len_next    = v4_group_len_reg;
        v4_group_value_next  = v4_group_value_reg;
        v4_leading_zero_next = v4_leading_zero_reg;
        if (!v4_fail_reg) begin
            if (is_dot) begin
                if (v4_group_len_reg == 2'd0 || v4_dot_count_reg == ipv_pkg::V4_MAX_DOTS) begin
                    v4_fail_next = 1'b1;
                end else begin
                    v4_dot_count_next    = v4_dot_count_reg + 2'd1;
                    v4_group_len_next    = 2'd0;
                    v4_group_value_next  = 8'd0;
                    v4_leading_zero_next = 1'b0;
                end
            end else if (is_dig) begin
                if (v4_group_len_reg == ipv_pkg::V4_MAX_LEN
                    || (v4_group_len_reg != 2'd0 && v4_leading_zero_reg)) begin
                    v4_fail_next = 1'b1;
                end else begin
                    if (v4_group_len_reg == 2'd0) begin
                        v4_leading_zero_next = (digit == 4'd0);
                    end
                    v4_group_value_next = v4_value_wide[7:0];
                    v4_group_len_next   = v4_group_len_reg + 2'd1;
                    if (v4_value_wide > ipv_pkg::V4_MAX_VALUE) begin
                        v4_fail_next = 1'b1;
                    end
                end
            end else begin
                v4_fail_next = 1'b1;
            end
        end

        // IPv6 checker
        v6_fail_next        = v6_fail_reg;
        v6_colon_count_next = v6_colon_count_reg;
        v6_group_len_next   = v6_group_len_reg;
        v6_saw_upper_next   = v6_saw_upper_reg;
        v6_saw_lower_next   = v6_saw_lower_reg;
        if (!v6_fail_reg) begin
            if (is_colon) begin
                if (v6_group_len_reg == 3'd0
                    || v6_colon_count_reg == ipv_pkg::V6_MAX_COLONS) begin
                    v6_fail_next = 1'b1;
                end else begin
                    v6_colon_count_next = v6_colon_count_reg + 3'd1;
                    v6_group_len_next   = 3'd0;
                    v6_saw_upper_next   = 1'b0;
                    v6_saw_lower_next   = 1'b0;
                end
            end else if (!(is_dig || is_low || is_up)
                         || v6_group_len_reg == ipv_pkg::V6_MAX_LEN
                         || (is_low && v6_saw_upper_reg)
                         || (is_up && v6_saw_lower_reg)) begin
                v6_fail_next = 1'b1;
            end else begin
                v6_saw_lower_next = v6_saw_lower_reg || is_low;
                v6_saw_upper_next = v6_saw_upper_reg || is_up;
                v6_group_len_next = v6_group_len_reg + 3'd1;
            end
        end

        verdict_next = ipv_pkg::VERDICT_ERROR;
        if (seen_dot_next) begin
            if (!v4_fail_next && v4_dot_count_next == ipv_pkg::V4_MAX_DOTS
                && v4_group_len_next != 2'd0) begin
                verdict_next = ipv_pkg::VERDICT_IPV4;
            end
        end else if (seen_colon_next) begin
            if (!v6_fail_next && v6_colon_count_next == ipv_pkg::V6_MAX_COLONS
                && v6_group_len_next != 3'd0) begin
                verdict_next = ipv_pkg::VERDICT_IPV6;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_is_last)) begin
            // clear on reset and after each finished string
            seen_dot_reg        <= 1'b0;
            seen_colon_reg      <= 1'b0;
            v4_fail_reg         <= 1'b0;
            v4_dot_count_reg    <= 2'd0;
            v4_group_len_reg    <= 2'd0;
            v4_group_value_reg  <= 8'd0;
            v4_leading_zero_reg <= 1'b0;
            v6_fail_reg         <= 1'b0;
            v6_colon_count_reg  <= 3'd0;
            v6_group_len_reg    <= 3'd0;
            v6_saw_upper_reg    <= 1'b0;
            v6_saw_lower_reg    <= 1'b0;
        end else if (accept) begin
            seen_dot_reg        <= seen_dot_next;
            seen_colon_reg      <= seen_colon_next;
            v4_fail_reg         <= v4_fail_next;
            v4_dot_count_reg    <= v4_dot_count_next;
            v4_group_len_reg    <= v4_group_len_next;
            v4_group_value_reg  <= v4_group_value_next;
            v4_leading_zero_reg <= v4_leading_zero_next;
            v6_fail_reg         <= v6_fail_next;
            v6_colon_count_reg  <= v6_colon_count_next;
            v6_group_len_reg    <= v6_group_len_next;
            v6_saw_upper_reg    <= v6_saw_upper_next;
            v6_saw_lower_reg    <= v6_saw_lower_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_is_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_is_last) begin
            m_verdict_reg <= verdict_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_last) |=> m_valid)
        else $error("last character did not produce a verdict");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_last) |=> (!seen_dot_reg && !seen_colon_reg
            && v4_dot_count_reg == 2'd0 && v6_colon_count_reg == 3'd0))
        else $error("checker state not cleared after last character");

    a_leading_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_leading_zero_reg |-> (v4_group_len_reg == 2'd1 || v4_fail_reg))
        else $error("leading zero group grew without failing");

    a_v6_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v6_group_len_reg <= ipv_pkg::V6_MAX_LEN)
        else $error("IPv6 group length out of range");
`endif

endmodule
